// ===== rtl/u16u8_pkg.sv =====
`timescale 1ns / 1ps

package u16u8_pkg;

  localparam int CP_W = 21;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef logic [CP_W-1:0] cp_t;

  typedef enum logic [1:0] {
    FMT_UTF16_LE = 2'd0,
    FMT_UTF16_BE = 2'd1,
    FMT_LATIN1   = 2'd2,
    FMT_LATIN1_X = 2'd3
  } src_fmt_t;

  // One code point handed from the front end to the queue, or from the queue head
  // to the back end.
  typedef struct packed {
    logic valid;
    cp_t  cp;
  } cp_beat_t;

  // Index of the final UTF-8 byte for a code point (sequence length minus one).
  function automatic logic [1:0] utf8_last_idx(input cp_t cp);
    logic [1:0] r;
    begin
      if (cp < CP_W'(32'h80)) begin
        r = 2'd0;
      end else if (cp < CP_W'(32'h800)) begin
        r = 2'd1;
      end else if (cp < CP_W'(32'h10000)) begin
        r = 2'd2;
      end else begin
        r = 2'd3;
      end
      return r;
    end
  endfunction

  // Byte number idx of the UTF-8 sequence of cp whose last index is last_idx.
  function automatic logic [7:0] utf8_byte(input cp_t cp, input logic [1:0] last_idx,
                                           input logic [1:0] idx);
    logic [1:0] grp;
    logic [5:0] six;
    logic [7:0] r;
    begin
      grp = last_idx - idx;
      case (grp)
        2'd0:    six = cp[5:0];
        2'd1:    six = cp[11:6];
        2'd2:    six = cp[17:12];
        default: six = {3'b000, cp[20:18]};
      endcase
      if (idx == 2'd0) begin
        case (last_idx)
          2'd0:    r = {1'b0, cp[6:0]};
          2'd1:    r = {3'b110, cp[10:6]};
          2'd2:    r = {4'b1110, cp[15:12]};
          default: r = {5'b11110, cp[20:18]};
        endcase
      end else begin
        r = {2'b10, six};
      end
      return r;
    end
  endfunction

endpackage

// ===== rtl/u16u8_front.sv =====
`timescale 1ns / 1ps

module u16u8_front
  import u16u8_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_data,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       stream_start,
  output cp_beat_t   push
);

  src_fmt_t    source_format;
  logic        byte_phase;
  logic [7:0]  held_byte;
  logic        high_pending;
  logic [9:0]  high_bits;

  logic        byte_phase_next;
  logic        high_pending_next;
  logic [9:0]  high_bits_next;
  logic        phase_eff;
  logic        pend_eff;
  logic [15:0] unit;
  logic        is_high;
  logic        is_low;

  assign phase_eff = stream_start ? 1'b0 : byte_phase;
  assign pend_eff  = stream_start ? 1'b0 : high_pending;
  assign unit = (source_format == FMT_UTF16_BE) ? {held_byte, in_byte} : {in_byte, held_byte};
  assign is_high = (unit[15:10] == 6'b110110);
  assign is_low  = (unit[15:10] == 6'b110111);

  always_comb begin
    byte_phase_next   = phase_eff;
    high_pending_next = pend_eff;
    high_bits_next    = high_bits;
    push.valid        = 1'b0;
    push.cp           = {{(CP_W-8){1'b0}}, in_byte};
    if (source_format[1]) begin
      // Latin-1: every byte is its own code point.
      byte_phase_next   = 1'b0;
      high_pending_next = 1'b0;
      push.valid        = accept;
    end else if (!phase_eff) begin
      byte_phase_next = 1'b1;
    end else begin
      byte_phase_next = 1'b0;
      if (pend_eff && is_low) begin
        high_pending_next = 1'b0;
        push.valid        = accept;
        push.cp           = CP_W'(32'h10000) + {1'b0, high_bits, unit[9:0]};
      end else if (is_high) begin
        // A new high surrogate replaces any one already waiting.
        high_pending_next = 1'b1;
        high_bits_next    = unit[9:0];
      end else begin
        high_pending_next = 1'b0;
        push.valid        = accept;
        push.cp           = {{(CP_W-16){1'b0}}, unit};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= FMT_UTF16_LE;
      byte_phase    <= 1'b0;
      held_byte     <= 8'd0;
      high_pending  <= 1'b0;
      high_bits     <= 10'd0;
    end else begin
      if (cfg_we) begin
        source_format <= src_fmt_t'(cfg_data);
      end
      if (accept) begin
        byte_phase   <= byte_phase_next;
        high_pending <= high_pending_next;
        high_bits    <= high_bits_next;
        if (!source_format[1] && !phase_eff) begin
          held_byte <= in_byte;
        end
      end
    end
  end

endmodule

// ===== rtl/u16u8_queue.sv =====
`timescale 1ns / 1ps

module u16u8_queue
  import u16u8_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cp_beat_t push,
  input  logic     pop,
  output cp_beat_t head,
  output logic     full
);

  cp_t               mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head.valid = (count != '0);
  assign head.cp    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.cp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push.valid) - QCNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push.valid |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head.valid)
    else $error("queue read while empty");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push.valid && !pop) |=> (count == $past(count) + QCNT_W'(1)))
    else $error("queue count did not follow a lone write");

endmodule

// ===== rtl/u16u8_back.sv =====
`timescale 1ns / 1ps

module u16u8_back
  import u16u8_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cp_beat_t   head,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast
);

  logic       busy;
  cp_t        cur_cp;
  logic [1:0] cur_last;
  logic [1:0] idx;
  logic       out_free;
  logic       step;
  logic       finishing;

  assign out_free  = !m_tvalid || m_tready;
  assign step      = busy && out_free;
  assign finishing = step && (idx == cur_last);
  // The next code point is fetched while its predecessor sends its final byte.
  assign pop       = head.valid && (!busy || finishing);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
      idx      <= 2'd0;
    end else begin
      if (step) begin
        m_tvalid <= 1'b1;
      end else if (out_free) begin
        m_tvalid <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
        idx  <= 2'd0;
      end else begin
        if (finishing) begin
          busy <= 1'b0;
        end
        if (step) begin
          idx <= idx + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= utf8_byte(cur_cp, cur_last, idx);
      m_tlast <= (idx == cur_last);
    end
    if (pop) begin
      cur_cp   <= head.cp;
      cur_last <= utf8_last_idx(head.cp);
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst) busy |-> (idx <= cur_last))
    else $error("byte index ran past the sequence end");
  a_pop_when_done: assert property (@(posedge clk) disable iff (rst)
    pop |-> (!busy || (out_free && idx == cur_last)))
    else $error("code point fetched while one is still being sent");
  a_step_loads: assert property (@(posedge clk) disable iff (rst) step |=> m_tvalid)
    else $error("emitted byte not presented");

endmodule

// ===== rtl/utf16_to_utf8_transcoder_top.sv =====
`timescale 1ns / 1ps

// Converts a byte stream in UTF-16 LE, UTF-16 BE or Latin-1 (set by cfg_data, written with
// cfg_we while idle) into UTF-8, one byte per output beat, with tlast on the final byte of
// each code point. An input beat is taken in every cycle while the four-entry code point
// queue has room; the output sends one UTF-8 byte per cycle unless held by m_axis_tready,
// so the output rate sets the sustained input rate (a Latin-1 byte above 0x7F becomes two
// UTF-8 bytes). A code point goes through the queue into the back end's code point
// register, and its bytes are registered onto the output. tuser high on an input beat
// clears byte pairing and any waiting high surrogate before that byte is used.
module utf16_to_utf8_transcoder_top
  import u16u8_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_data,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tuser,   // [0] stream_start
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast
);

  cp_beat_t push;
  cp_beat_t head;
  logic     pop;
  logic     full;
  logic     accept;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  u16u8_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .in_byte      (s_axis_tdata),
    .stream_start (s_axis_tuser),
    .push         (push)
  );

  u16u8_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (full)
  );

  u16u8_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_tdata  (m_axis_tdata),
    .m_tlast  (m_axis_tlast)
  );

endmodule
